### hdl/pbrb_pkg.sv
// ----------------------------------------------------------------------------
// pbrb_pkg
// Shared constants, codes and types of the packed-byte log ring buffer.
// ----------------------------------------------------------------------------
package pbrb_pkg;

  localparam int BUFFER_BYTES = 16384;
  localparam int SECTOR_BYTES = 512;
  localparam int MAX_SECTORS  = 32;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int SECTOR_LOG   = $clog2(SECTOR_BYTES);
  localparam int THR_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 8;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);
  localparam logic [CNT_W-1:0] SECTOR_MASK = ~CNT_W'(SECTOR_BYTES - 1);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_LEN      = 2'd1,
    ST_NO_ROOM      = 2'd2,
    ST_OVER_RELEASE = 2'd3
  } status_t;

  // register index within the configuration space
  localparam logic REG_FLUSH_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [LEN_W-1:0]  packed_length;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] third_byte;
    logic [CNT_W-1:0]  release_length;
    logic [ADDR_W-1:0] read_address;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] chunk_offset;
    logic [CNT_W-1:0]  chunk_length;
    logic [BYTE_W-1:0] read_data;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  high_water;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       mem_we;
    logic [1:0] byte_sel;
    logic       mem_re;
    logic       finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t    action;
    logic       write_ok;
    logic [1:0] last_sel;
  } dp_stat_t;

endpackage

### hdl/pbrb_if.sv
// ----------------------------------------------------------------------------
// pbrb_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface pbrb_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [pbrb_pkg::LEN_W-1:0]    packed_length;
  logic [pbrb_pkg::BYTE_W-1:0]   first_byte;
  logic [pbrb_pkg::BYTE_W-1:0]   second_byte;
  logic [pbrb_pkg::BYTE_W-1:0]   third_byte;
  logic [pbrb_pkg::CNT_W-1:0]    release_length;
  logic [pbrb_pkg::ADDR_W-1:0]   read_address;

  modport source (
    output valid, action, packed_length, first_byte, second_byte, third_byte,
           release_length, read_address,
    input  ready
  );
  modport sink (
    input  valid, action, packed_length, first_byte, second_byte, third_byte,
           release_length, read_address,
    output ready
  );
endinterface

interface pbrb_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [pbrb_pkg::ADDR_W-1:0]   chunk_offset;
  logic [pbrb_pkg::CNT_W-1:0]    chunk_length;
  logic [pbrb_pkg::BYTE_W-1:0]   read_data;
  logic [pbrb_pkg::CNT_W-1:0]    fill_level;
  logic [pbrb_pkg::CNT_W-1:0]    high_water;

  modport source (
    output valid, status, chunk_offset, chunk_length, read_data, fill_level,
           high_water,
    input  ready
  );
  modport sink (
    input  valid, status, chunk_offset, chunk_length, read_data, fill_level,
           high_water,
    output ready
  );
endinterface

### hdl/pbrb_ram.sv
// ----------------------------------------------------------------------------
// pbrb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/pbrb_cfg.sv
// ----------------------------------------------------------------------------
// pbrb_cfg
// APB register slave holding the flush threshold.
// ----------------------------------------------------------------------------
module pbrb_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pbrb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pbrb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pbrb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [pbrb_pkg::THR_W-1:0]        thr_o
);
  import pbrb_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [THR_W-1:0] thr_nxt;
  logic             sel_thr;

  // word index sits above the byte lanes
  assign sel_thr = (paddr[APB_ADDR_W-1] == REG_FLUSH_THRESHOLD);

  always_comb begin
    thr_nxt = thr_r;
    if (psel && penable && pwrite && sel_thr) begin
      thr_nxt = pwdata[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign prdata = sel_thr ? APB_DATA_W'(thr_r) : '0;
  assign pready = 1'b1;
  assign thr_o  = thr_r;

endmodule

### hdl/pbrb_ctrl.sv
// ----------------------------------------------------------------------------
// pbrb_ctrl
// Sequencer: takes one item, steps the byte writes or the read, then
// presents the result until it is taken.
// ----------------------------------------------------------------------------
module pbrb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pbrb_pkg::dp_stat_t stat_i,
  output pbrb_pkg::cmd_t     cmd_o
);
  import pbrb_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.action == ACT_WRITE && stat_i.write_ok) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WRITE: begin
        if (idx_r == stat_i.last_sel) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    idx_nxt   = 2'd0;
    case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd_o.load_item = in_valid;
      end
      S_DECODE: begin
        cmd_o.mem_re = (stat_i.action == ACT_READ);
      end
      S_WRITE: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.byte_sel = idx_r;
        idx_nxt        = idx_r + 2'd1;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

### hdl/pbrb_dp.sv
// ----------------------------------------------------------------------------
// pbrb_dp
// Datapath: item register, ring pointers, fill and peak counters, byte
// store and the result register.
// ----------------------------------------------------------------------------
module pbrb_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pbrb_pkg::item_t            item_i,
  input  logic [pbrb_pkg::THR_W-1:0] thr_i,
  input  pbrb_pkg::cmd_t             cmd_i,
  output pbrb_pkg::dp_stat_t         stat_o,
  output pbrb_pkg::res_t             res_o
);
  import pbrb_pkg::*;

  item_t             item_r;
  res_t              res_r;
  res_t              res_nxt;
  logic [ADDR_W-1:0] head_r;
  logic [ADDR_W-1:0] head_nxt;
  logic [ADDR_W-1:0] tail_r;
  logic [ADDR_W-1:0] tail_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [CNT_W-1:0]  peak_r;
  logic [CNT_W-1:0]  peak_nxt;

  logic [BYTE_W-1:0] wr_byte;
  logic [BYTE_W-1:0] rd_byte;
  logic              len_ok;
  logic              room_ok;
  logic [CNT_W:0]    fill_plus;
  logic [CNT_W-1:0]  wr_fill;

  logic [THR_W-1:0]  sectors;
  logic [CNT_W-1:0]  thresh;
  logic [CNT_W-1:0]  grant_fill;
  logic [CNT_W-1:0]  grant_thr;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  grant;
  logic [CNT_W-1:0]  rel_sum;
  logic [CNT_W-1:0]  rel_wrap;

  // ---------------- write admission ----------------
  assign len_ok    = (item_r.packed_length >= LEN_W'(1)) &&
                     (item_r.packed_length <= LEN_W'(3));
  assign fill_plus = {1'b0, fill_r} + (CNT_W+1)'(item_r.packed_length[1:0]);
  assign room_ok   = (fill_plus <= (CNT_W+1)'(BUFFER_BYTES));
  assign wr_fill   = fill_plus[CNT_W-1:0];

  assign stat_o.action   = action_t'(item_r.action);
  assign stat_o.write_ok = len_ok && room_ok;
  assign stat_o.last_sel = item_r.packed_length[1:0] - 2'd1;

  // ---------------- byte store ----------------
  always_comb begin
    case (cmd_i.byte_sel)
      2'd0:    wr_byte = item_r.first_byte;
      2'd1:    wr_byte = item_r.second_byte;
      default: wr_byte = item_r.third_byte;
    endcase
  end

  pbrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd_i.mem_we),
    .waddr (head_r),
    .wdata (wr_byte),
    .re    (cmd_i.mem_re),
    .raddr (item_r.read_address),
    .rdata (rd_byte)
  );

  // ---------------- chunk sizing ----------------
  always_comb begin
    if (thr_i == '0) begin
      sectors = THR_W'(1);
    end else if (thr_i > THR_W'(MAX_SECTORS)) begin
      sectors = THR_W'(MAX_SECTORS);
    end else begin
      sectors = thr_i;
    end
  end

  assign thresh     = CNT_W'(sectors) << SECTOR_LOG;
  assign grant_fill = fill_r & SECTOR_MASK;
  assign grant_thr  = (grant_fill > thresh) ? thresh : grant_fill;
  // room up to the end of the ring, whole sectors only
  assign room       = (CNT_W'(BUFFER_BYTES) - {1'b0, tail_r}) & SECTOR_MASK;
  assign grant      = (grant_thr > room) ? room : grant_thr;

  // ---------------- release ----------------
  assign rel_sum  = {1'b0, tail_r} + item_r.release_length;
  assign rel_wrap = (rel_sum >= CNT_W'(BUFFER_BYTES)) ?
                    rel_sum - CNT_W'(BUFFER_BYTES) : rel_sum;

  // ---------------- state update and result ----------------
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    peak_nxt = peak_r;
    res_nxt  = res_r;

    if (cmd_i.mem_we) begin
      head_nxt = (head_r == ADDR_W'(BUFFER_BYTES - 1)) ? '0 : head_r + ADDR_W'(1);
    end

    if (cmd_i.finish) begin
      res_nxt.status       = ST_OK;
      res_nxt.chunk_offset = '0;
      res_nxt.chunk_length = '0;
      res_nxt.read_data    = '0;
      case (action_t'(item_r.action))
        ACT_WRITE: begin
          if (!len_ok) begin
            res_nxt.status = ST_BAD_LEN;
          end else if (!room_ok) begin
            res_nxt.status = ST_NO_ROOM;
          end else begin
            fill_nxt = wr_fill;
            if (wr_fill > peak_r) begin
              peak_nxt = wr_fill;
            end
          end
        end
        ACT_QUERY: begin
          res_nxt.chunk_offset = tail_r;
          if (fill_r >= thresh && grant >= CNT_W'(SECTOR_BYTES)) begin
            res_nxt.chunk_length = grant;
          end
        end
        ACT_RELEASE: begin
          if (item_r.release_length > fill_r) begin
            res_nxt.status = ST_OVER_RELEASE;
          end else begin
            tail_nxt = rel_wrap[ADDR_W-1:0];
            fill_nxt = fill_r - item_r.release_length;
          end
        end
        ACT_READ: begin
          res_nxt.read_data = rd_byte;
        end
        default: begin
          res_nxt.status = ST_OK;
        end
      endcase
      res_nxt.fill_level = fill_nxt;
      res_nxt.high_water = peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      peak_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      peak_r <= peak_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd_i.load_item) begin
      item_r <= item_i;
    end
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

### hdl/packed_byte_log_ring_buffer.sv
// ----------------------------------------------------------------------------
// packed_byte_log_ring_buffer
// Byte ring buffer for a log stream with sector-sized drain grants.
// ----------------------------------------------------------------------------
// Items arrive on in_ch (valid/ready) and each gives exactly one result on
// out_ch (valid/ready). An item is one of: write up to three packed bytes,
// query a drain chunk, release drained bytes, or read one stored byte.
// The flush threshold (in 512-byte sectors) sits in an APB register at
// address 0; the user must write it only while the block is idle, which
// the block itself does not enforce. One item is handled at a time. From
// acceptance an item passes through the decode state, one write step per
// byte for an accepted write, and the finish state, where the result is
// registered; the byte store has a single write port, so packed bytes go
// in one per cycle. in_ch is ready again the cycle after the result is
// taken.
// Reset (synchronous, active low) empties the ring, clears the high-water
// mark and sets the threshold to 8 sectors; the byte store is not cleared.
// While out_ch is stalled the result is held and no new item is taken.
// ----------------------------------------------------------------------------
module packed_byte_log_ring_buffer (
  input  logic                            clk,
  input  logic                            rst_n,
  pbrb_in_if.sink                         in_ch,
  pbrb_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbrb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pbrb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pbrb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import pbrb_pkg::*;

  item_t            item;
  res_t             res;
  cmd_t             cmd;
  dp_stat_t         stat;
  logic [THR_W-1:0] thr;

  assign item.action         = in_ch.action;
  assign item.packed_length  = in_ch.packed_length;
  assign item.first_byte     = in_ch.first_byte;
  assign item.second_byte    = in_ch.second_byte;
  assign item.third_byte     = in_ch.third_byte;
  assign item.release_length = in_ch.release_length;
  assign item.read_address   = in_ch.read_address;

  pbrb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr_o   (thr)
  );

  pbrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pbrb_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .item_i (item),
    .thr_i  (thr),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  assign out_ch.status       = res.status;
  assign out_ch.chunk_offset = res.chunk_offset;
  assign out_ch.chunk_length = res.chunk_length;
  assign out_ch.read_data    = res.read_data;
  assign out_ch.fill_level   = res.fill_level;
  assign out_ch.high_water   = res.high_water;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the packed-byte log ring buffer.
// Log writes, chunk queries, releases and byte reads go in on the item
// channel. A local mirror of the ring predicts every result, and each result
// is compared field by field in arrival order. The sender idles in random
// bursts, and the receiver stalls on a changing pattern. The flush threshold
// is rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module tb;
  import pbrb_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LINES  = 100;
  localparam int STREAM_PHASES = 7;
  localparam int PHASE_ITEMS   = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pbrb_in_if  in_ch ();
  pbrb_out_if out_ch ();

  packed_byte_log_ring_buffer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the ring
  logic [BYTE_W-1:0] ring_mem [BUFFER_BYTES];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       ring_fill;
  int unsigned       ring_peak;
  int unsigned       written_span;   // entries 0 .. span-1 hold written bytes
  logic [THR_W-1:0]  thr_sectors;

  res_t              pending_results[$];
  logic [CNT_W-1:0]  open_grant;
  int                mismatch_count = 0;
  int                burst_left = 0;
  int                cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("packed_byte_log_ring_buffer test failed");
      $finish;
    end
  end

  function automatic void store_byte(input logic [BYTE_W-1:0] value);
    ring_mem[ring_head] = value;
    if (ring_head == written_span && written_span < BUFFER_BYTES) written_span++;
    ring_head = (ring_head + 1) % BUFFER_BYTES;
  endfunction

  function automatic res_t ring_step(input item_t it);
    res_t        r;
    int unsigned len;
    int unsigned sectors;
    int unsigned thresh;
    int unsigned grant;
    int unsigned room;
    int unsigned rel;
    r = '0;
    len = it.packed_length;
    case (action_t'(it.action))
      ACT_WRITE: begin
        if (len < 1 || len > 3) begin
          r.status = ST_BAD_LEN;
        end else if (ring_fill + len > BUFFER_BYTES) begin
          r.status = ST_NO_ROOM;
        end else begin
          store_byte(it.first_byte);
          if (len >= 2) store_byte(it.second_byte);
          if (len == 3) store_byte(it.third_byte);
          ring_fill += len;
          if (ring_fill > ring_peak) ring_peak = ring_fill;
        end
      end
      ACT_QUERY: begin
        // saturate the threshold to 1 .. MAX_SECTORS
        sectors = thr_sectors;
        if (sectors < 1) sectors = 1;
        if (sectors > MAX_SECTORS) sectors = MAX_SECTORS;
        thresh = sectors * SECTOR_BYTES;
        r.chunk_offset = ADDR_W'(ring_tail);
        if (ring_fill >= thresh) begin
          grant = ring_fill - ring_fill % SECTOR_BYTES;
          if (grant > thresh) grant = thresh;
          room = BUFFER_BYTES - ring_tail;
          room -= room % SECTOR_BYTES;
          if (grant > room) grant = room;
          if (grant >= SECTOR_BYTES) r.chunk_length = CNT_W'(grant);
        end
      end
      ACT_RELEASE: begin
        rel = it.release_length;
        if (rel > ring_fill) begin
          r.status = ST_OVER_RELEASE;
        end else begin
          ring_tail += rel;
          if (ring_tail >= BUFFER_BYTES) ring_tail -= BUFFER_BYTES;
          ring_fill -= rel;
        end
      end
      default: begin
        r.read_data = ring_mem[it.read_address];
      end
    endcase
    r.fill_level = CNT_W'(ring_fill);
    r.high_water = CNT_W'(ring_peak);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want);
    if (mismatch_count < REPORT_LINES)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with no item outstanding", out_ch.fill_level, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          log_mismatch("status", out_ch.status, want.status);
        if (out_ch.chunk_offset !== want.chunk_offset)
          log_mismatch("chunk_offset", out_ch.chunk_offset, want.chunk_offset);
        if (out_ch.chunk_length !== want.chunk_length)
          log_mismatch("chunk_length", out_ch.chunk_length, want.chunk_length);
        if (out_ch.read_data !== want.read_data)
          log_mismatch("read_data", out_ch.read_data, want.read_data);
        if (out_ch.fill_level !== want.fill_level)
          log_mismatch("fill_level", out_ch.fill_level, want.fill_level);
        if (out_ch.high_water !== want.high_water)
          log_mismatch("high_water", out_ch.high_water, want.high_water);
      end
    end
  end

  // Receiver: switch between stall patterns every so often.
  initial begin
    int          stall_mode;
    int          mode_left;
    int unsigned beat;
    stall_mode = 0;
    mode_left = 0;
    beat = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      beat++;
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (beat % 3) == 0;
        default: out_ch.ready <= (beat % 16) >= 11;
      endcase
    end
  end

  // Sender pacing: hold valid high through a burst, then drop it for a gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic send_item(input item_t it, output res_t want);
    in_ch.valid          <= 1'b1;
    in_ch.action         <= it.action;
    in_ch.packed_length  <= it.packed_length;
    in_ch.first_byte     <= it.first_byte;
    in_ch.second_byte    <= it.second_byte;
    in_ch.third_byte     <= it.third_byte;
    in_ch.release_length <= it.release_length;
    in_ch.read_address   <= it.read_address;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = ring_step(it);
    pending_results.push_back(want);
    pace_sender();
  endtask

  // Fields the action does not use carry random values.
  function automatic item_t random_item(input action_t act);
    item_t it;
    it.action         = act;
    it.packed_length  = LEN_W'($urandom_range(0, 255));
    it.first_byte     = BYTE_W'($urandom_range(0, 255));
    it.second_byte    = BYTE_W'($urandom_range(0, 255));
    it.third_byte     = BYTE_W'($urandom_range(0, 255));
    it.release_length = CNT_W'($urandom_range(0, 32767));
    it.read_address   = ADDR_W'($urandom_range(0, BUFFER_BYTES - 1));
    return it;
  endfunction

  task automatic do_write(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] b0,
                          input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2);
    item_t it;
    res_t  want;
    it = random_item(ACT_WRITE);
    it.packed_length = len;
    it.first_byte = b0;
    it.second_byte = b1;
    it.third_byte = b2;
    send_item(it, want);
  endtask

  task automatic do_random_write(input logic [LEN_W-1:0] len);
    do_write(len, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
             BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic do_query(output logic [CNT_W-1:0] grant);
    res_t want;
    send_item(random_item(ACT_QUERY), want);
    grant = want.chunk_length;
  endtask

  task automatic do_release(input logic [CNT_W-1:0] rel);
    item_t it;
    res_t  want;
    it = random_item(ACT_RELEASE);
    it.release_length = rel;
    send_item(it, want);
  endtask

  // Only offsets below written_span may be read.
  task automatic do_read(input logic [ADDR_W-1:0] addr);
    item_t it;
    res_t  want;
    it = random_item(ACT_READ);
    it.read_address = addr;
    send_item(it, want);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] sectors);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FLUSH_THRESHOLD, 2'b00};
    pwdata  <= {(APB_DATA_W-THR_W)'($urandom), sectors};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thr_sectors = sectors;
    @(posedge clk);
  endtask

  task automatic test_basic_operations();
    logic [CNT_W-1:0] grant;
    do_write(8'd0, 8'h12, 8'h34, 8'h56);
    do_write(8'd4, 8'h12, 8'h34, 8'h56);
    do_write(8'd255, 8'hFF, 8'hFF, 8'hFF);
    do_query(grant);                       // empty ring grants nothing
    do_release(15'd1);                     // nothing to free yet
    do_write(8'd1, 8'h00, 8'hFF, 8'hFF);
    do_write(8'd2, 8'hFF, 8'h80, 8'h00);
    do_write(8'd3, 8'h01, 8'h7F, 8'hAA);
    do_read(14'd0);
    do_read(14'd2);
    do_read(14'd5);
    do_query(grant);                       // fill below threshold
    do_release(15'h7FFF);
    do_release(15'd7);
    do_release(15'd0);
    do_release(15'd2);
    do_query(grant);                       // offset follows the tail
    do_read(14'd1);
  endtask

  task automatic test_fill_to_full();
    logic [CNT_W-1:0] grant;
    int unsigned      left;
    int unsigned      len;
    while (ring_fill < BUFFER_BYTES) begin
      left = BUFFER_BYTES - ring_fill;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 3;
      if (len > left) len = left;
      do_random_write(LEN_W'(len));
    end
    do_random_write(8'd1);
    do_random_write(8'd3);
    do_query(grant);
    set_threshold(6'd32);
    do_query(grant);
    set_threshold(6'd0);
    do_query(grant);
    set_threshold(6'd63);
    do_query(grant);
    set_threshold(6'd33);
    do_query(grant);
    do_read(14'd0);
    do_read(14'h3FFF);
    do_read(14'h2000);
    do_read(14'h1FFF);
    repeat (12) do_read(ADDR_W'($urandom_range(0, written_span - 1)));
    do_release(CNT_W'(BUFFER_BYTES + 1));
  endtask

  // Drain by granted chunks, each capped at the end of the ring, until a query grants nothing.
  task automatic test_drain_walk();
    logic [CNT_W-1:0] grant;
    set_threshold(6'd8);
    do_query(grant);
    while (grant != 0) begin
      do_release(grant);
      do_query(grant);
    end
    set_threshold(6'd1);
    do_query(grant);
    do_release(CNT_W'(ring_fill));         // tail crosses the end of the ring
    do_query(grant);
  endtask

  task automatic test_log_stream();
    logic [THR_W-1:0] thr_plan [STREAM_PHASES];
    logic [CNT_W-1:0] grant;
    int unsigned      rel;
    int unsigned      cap;
    int               pick;
    int               sel;
    thr_plan = '{6'd1, 6'd0, 6'd2, 6'd1, 6'd32, 6'd1, 6'd1};
    thr_plan[5] = THR_W'($urandom_range(0, 63));
    open_grant = '0;
    for (int p = 0; p < STREAM_PHASES; p++) begin
      set_threshold(thr_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) do_random_write(LEN_W'($urandom_range(0, 255)));
          else if (sel < 3) do_random_write(LEN_W'($urandom_range(1, 2)));
          else do_random_write(8'd3);
        end else if (pick < 78) begin
          do_query(grant);
          if (grant != 0) open_grant = grant;
        end else if (pick < 92) begin
          sel = $urandom_range(0, 9);
          cap = (ring_fill < 24) ? ring_fill : 24;
          if (sel < 5 && open_grant != 0 && open_grant <= ring_fill) begin
            rel = open_grant;
            open_grant = '0;
          end else if (sel < 8) begin
            rel = $urandom_range(0, cap);
          end else if (sel == 8) begin
            rel = $urandom_range(ring_fill + 1, ring_fill + 600);
          end else begin
            rel = $urandom_range(0, 32767);
          end
          do_release(CNT_W'(rel));
        end else if (written_span > 0) begin
          do_read(ADDR_W'($urandom_range(0, written_span - 1)));
        end else begin
          do_query(grant);
        end
      end
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= '0;
    in_ch.packed_length  <= '0;
    in_ch.first_byte     <= '0;
    in_ch.second_byte    <= '0;
    in_ch.third_byte     <= '0;
    in_ch.release_length <= '0;
    in_ch.read_address   <= '0;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    ring_peak = 0;
    written_span = 0;
    thr_sectors = THR_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_operations();
    test_fill_to_full();
    test_drain_walk();
    test_log_stream();
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("packed_byte_log_ring_buffer test passed");
    end else begin
      $display("packed_byte_log_ring_buffer test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/pbrb_pkg.sv
hdl/pbrb_if.sv
hdl/pbrb_ram.sv
hdl/pbrb_cfg.sv
hdl/pbrb_ctrl.sv
hdl/pbrb_dp.sv
hdl/packed_byte_log_ring_buffer.sv
tb/sv/tb.sv
